// File: design/vtil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtil_pkg
// Shared types and constants for the vector triple index lookup.
// ----------------------------------------------------------------------------
package vtil_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int COORD_BITS_DEF  = 16;
  localparam int IN_COORD_W      = 16;
  localparam int OUT_IDX_W       = 11;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // control part of a beat moving down the cell chain
  typedef struct packed {
    func_t op;
    logic  hit;
    logic  last;
  } ctl_t;

endpackage

// File: design/vtil_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtil_req_if / vtil_rsp_if
// Request and response channels of the vector triple index lookup.
// ----------------------------------------------------------------------------
interface vtil_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic              last_in_batch;

  modport source (output valid, func, coord_x, coord_y, coord_z, last_in_batch,
                  input ready);
  modport sink   (input valid, func, coord_x, coord_y, coord_z, last_in_batch,
                  output ready);
endinterface

interface vtil_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] match_index;
  logic               found;
  logic               last;

  modport source (output valid, match_index, found, last, input ready);
  modport sink   (input valid, match_index, found, last, output ready);
endinterface

// File: design/vtil_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtil_cell
// One table slot: holds a vector, stores appends aimed at its index and
// marks the first match for searches passing through.
// ----------------------------------------------------------------------------
module vtil_cell
  import vtil_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int IDX_W      = 10,
  parameter int CNT_W      = 11,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  ctl_t                  ctl_d,
  input  logic [COORD_BITS-1:0] x_d,
  input  logic [COORD_BITS-1:0] y_d,
  input  logic [COORD_BITS-1:0] z_d,
  input  logic [IDX_W-1:0]      idx_d,
  input  logic [CNT_W-1:0]      limit_d,
  output ctl_t                  ctl_q,
  output logic [COORD_BITS-1:0] x_q,
  output logic [COORD_BITS-1:0] y_q,
  output logic [COORD_BITS-1:0] z_q,
  output logic [IDX_W-1:0]      idx_q,
  output logic [CNT_W-1:0]      limit_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

  logic [COORD_BITS-1:0] ent_x;
  logic [COORD_BITS-1:0] ent_y;
  logic [COORD_BITS-1:0] ent_z;
  logic                  match;
  ctl_t                  ctl_next;
  logic [IDX_W-1:0]      idx_next;

  assign match = (ctl_d.op == FUNC_SEARCH) && !ctl_d.hit && (MY_CNT < limit_d) &&
                 (ent_x == x_d) && (ent_y == y_d) && (ent_z == z_d);

  always_comb begin
    ctl_next = ctl_d;
    idx_next = idx_d;
    if (match) begin
      ctl_next.hit = 1'b1;
      idx_next     = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '{op: FUNC_NONE, hit: 1'b0, last: 1'b0};
    end else if (adv) begin
      ctl_q <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      idx_q   <= idx_next;
      limit_q <= limit_d;
      if (ctl_d.op == FUNC_APPEND && idx_d == MY_IDX) begin
        ent_x <= x_d;
        ent_y <= y_d;
        ent_z <= z_d;
      end
    end
  end

endmodule

// File: design/vector_triple_index_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_triple_index_lookup
// Exact-match table of integer 3-vectors built as a chain of slot cells.
//
//   channel  dir  beat
//   req      in   func, coord_x, coord_y, coord_z, last_in_batch
//   rsp      out  match_index, found, last (searches only)
//
// One request per cycle enters the chain unless a stalled rsp beat holds it; a
// search answer passes through each cell of the chain, then the rsp register.
// Reset empties the table; entries are never read before written.
// A stalled rsp beat freezes the whole chain and holds req.ready low.
// ----------------------------------------------------------------------------
module vector_triple_index_lookup
  import vtil_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  vtil_req_if.sink    req,
  vtil_rsp_if.source  rsp
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  logic                  adv;
  logic                  acc;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  ctl_t                  ctl_in;
  logic [IDX_W-1:0]      idx_in;

  ctl_t                  ctl_c   [TABLE_DEPTH+1];
  logic [COORD_BITS-1:0] x_c     [TABLE_DEPTH+1];
  logic [COORD_BITS-1:0] y_c     [TABLE_DEPTH+1];
  logic [COORD_BITS-1:0] z_c     [TABLE_DEPTH+1];
  logic [IDX_W-1:0]      idx_c   [TABLE_DEPTH+1];
  logic [CNT_W-1:0]      limit_c [TABLE_DEPTH+1];

  logic [EXT_W-1:0]      idx_ext;

  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;
  assign acc       = req.valid && adv;

  always_comb begin
    count_next  = count;
    ctl_in.op   = FUNC_NONE;
    ctl_in.hit  = 1'b0;
    ctl_in.last = req.last_in_batch;
    idx_in      = count[IDX_W-1:0];
    if (acc) begin
      case (req.func)
        FUNC_CLEAR: begin
          count_next = '0;
        end
        FUNC_APPEND: begin
          if (count < DEPTH_CNT) begin
            count_next = count + 1'b1;
            ctl_in.op  = FUNC_APPEND;
          end
        end
        FUNC_SEARCH: begin
          ctl_in.op = FUNC_SEARCH;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign ctl_c[0]   = ctl_in;
  assign x_c[0]     = COORD_BITS'(req.coord_x);
  assign y_c[0]     = COORD_BITS'(req.coord_y);
  assign z_c[0]     = COORD_BITS'(req.coord_z);
  assign idx_c[0]   = idx_in;
  assign limit_c[0] = count;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    vtil_cell #(
      .IDX        (i),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .ctl_d   (ctl_c[i]),
      .x_d     (x_c[i]),
      .y_d     (y_c[i]),
      .z_d     (z_c[i]),
      .idx_d   (idx_c[i]),
      .limit_d (limit_c[i]),
      .ctl_q   (ctl_c[i+1]),
      .x_q     (x_c[i+1]),
      .y_q     (y_c[i+1]),
      .z_q     (z_c[i+1]),
      .idx_q   (idx_c[i+1]),
      .limit_q (limit_c[i+1])
    );
  end

  assign idx_ext = EXT_W'(idx_c[TABLE_DEPTH]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= (ctl_c[TABLE_DEPTH].op == FUNC_SEARCH);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.found       <= ctl_c[TABLE_DEPTH].hit;
      rsp.last        <= ctl_c[TABLE_DEPTH].last;
      rsp.match_index <= ctl_c[TABLE_DEPTH].hit ? idx_ext[OUT_IDX_W-1:0] : '1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("entry count beyond table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.func == FUNC_CLEAR) |=> (count == '0))
    else $error("clear did not empty table");

  a_miss_code: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.match_index == '1))
    else $error("miss without all-ones index");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.func == FUNC_APPEND && count == DEPTH_CNT)
    |=> (count == DEPTH_CNT))
    else $error("append past capacity changed count");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the vector triple index lookup.
// Drives clear/append/search/none beats, predicts each search answer from a
// local mirror of the table, and checks every answer in order. Both
// channels idle at random; one long response hold backs up the cell chain.
// ----------------------------------------------------------------------------
module tb;
  import vtil_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int CB    = COORD_BITS_DEF;

  typedef struct packed {
    logic signed [OUT_IDX_W-1:0] idx;
    logic                        found;
    logic                        last;
  } answer_t;

  logic clk;
  logic rst;

  vtil_req_if req_bus ();
  vtil_rsp_if rsp_bus ();

  vector_triple_index_lookup #(
    .TABLE_DEPTH(DEPTH),
    .COORD_BITS (CB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  logic [3*CB-1:0] mirror_tbl [DEPTH];
  int              mirror_count;
  answer_t         pending_answers[$];
  int              mismatch_count;

  bit src_idling;
  bit sink_idling;
  int hold_on_result;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [CB-1:0] coord_key(logic [15:0] c);
    logic [63:0] w;
    w = {{48{c[15]}}, c};
    return w[CB-1:0];
  endfunction

  // mirror of the table: lowest matching index wins
  function automatic void mirror_step(func_t f, logic [47:0] v, logic lb);
    logic [3*CB-1:0] key;
    answer_t         a;
    int              hit_at;
    key = {coord_key(v[47:32]), coord_key(v[31:16]), coord_key(v[15:0])};
    case (f)
      FUNC_CLEAR: begin
        mirror_count = 0;
      end
      FUNC_APPEND: begin
        if (mirror_count < DEPTH) begin
          mirror_tbl[mirror_count] = key;
          mirror_count++;
        end
      end
      FUNC_SEARCH: begin
        hit_at = -1;
        for (int i = 0; i < mirror_count; i++) begin
          if (mirror_tbl[i] == key) begin
            hit_at = i;
            break;
          end
        end
        a.found = (hit_at >= 0);
        a.idx   = a.found ? hit_at[OUT_IDX_W-1:0] : {OUT_IDX_W{1'b1}};
        a.last  = lb;
        pending_answers.push_back(a);
      end
      default: ;
    endcase
  endfunction

  task automatic put_item(input func_t f, input logic [47:0] v, input logic lb);
    int gap;
    @(negedge clk);
    req_bus.valid         <= 1'b1;
    req_bus.func          <= f;
    req_bus.coord_x       <= v[47:32];
    req_bus.coord_y       <= v[31:16];
    req_bus.coord_z       <= v[15:0];
    req_bus.last_in_batch <= lb;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    mirror_step(f, v, lb);
    gap = (src_idling && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_vec(bit narrow);
    logic [15:0] c [3];
    for (int k = 0; k < 3; k++) begin
      if (narrow) begin
        c[k] = 16'($urandom_range(0, 3));
        c[k] = c[k] - 16'd2;
      end else begin
        c[k] = 16'($urandom);
      end
    end
    return {c[0], c[1], c[2]};
  endfunction

  function automatic logic [47:0] near_miss(logic [47:0] v);
    return v ^ (48'd1 << $urandom_range(0, 47));
  endfunction

  // receiver: random stalls, plus one long hold on a result when armed
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_on_result > 0 && rsp_bus.valid) begin
        rsp_bus.ready <= 1'b0;
        repeat (hold_on_result) @(negedge clk);
        hold_on_result = 0;
      end else if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_bus.ready <= 1'b1;
        if (sink_idling && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin : check_rsp
    answer_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual idx=%0d found=%0b last=%0b",
                 $time, rsp_bus.match_index, rsp_bus.found, rsp_bus.last);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        if (rsp_bus.match_index !== want.idx) begin
          $display("%0t: match_index mismatch: expected %0d, actual %0d",
                   $time, want.idx, rsp_bus.match_index);
          mismatch_count++;
        end
        if (rsp_bus.found !== want.found) begin
          $display("%0t: found mismatch: expected %0b, actual %0b",
                   $time, want.found, rsp_bus.found);
          mismatch_count++;
        end
        if (rsp_bus.last !== want.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, want.last, rsp_bus.last);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_empty_table();
    put_item(FUNC_CLEAR, 48'h0, 1'b1);
    put_item(FUNC_SEARCH, 48'h0, 1'b0);
    put_item(FUNC_SEARCH, {16'h7FFF, 16'h8000, 16'hFFFF}, 1'b1);
  endtask

  task automatic test_unused_code();
    put_item(FUNC_NONE, {16'd1, 16'd2, 16'd3}, 1'b1);
    put_item(FUNC_SEARCH, {16'd1, 16'd2, 16'd3}, 1'b1);
  endtask

  task automatic test_field_extremes();
    put_item(FUNC_APPEND, {3{16'h7FFF}}, 1'b1);
    put_item(FUNC_APPEND, {3{16'h8000}}, 1'b0);
    put_item(FUNC_APPEND, {16'h0000, 16'hFFFF, 16'h8000}, 1'b1);
    put_item(FUNC_SEARCH, {3{16'h7FFF}}, 1'b0);
    put_item(FUNC_SEARCH, {3{16'h8000}}, 1'b1);
    put_item(FUNC_SEARCH, {16'h0000, 16'hFFFF, 16'h8000}, 1'b0);
    put_item(FUNC_SEARCH, {16'h7FFF, 16'h7FFF, 16'h7FFE}, 1'b1);
  endtask

  task automatic test_duplicates();
    put_item(FUNC_APPEND, 48'h0, 1'b0);
    put_item(FUNC_APPEND, {3{16'h8000}}, 1'b0);
    put_item(FUNC_SEARCH, {3{16'h8000}}, 1'b0);
    put_item(FUNC_SEARCH, 48'h0, 1'b1);
  endtask

  task automatic test_clear_hides_old();
    put_item(FUNC_CLEAR, 48'h0, 1'b0);
    put_item(FUNC_APPEND, {3{16'd5}}, 1'b0);
    put_item(FUNC_SEARCH, {3{16'h7FFF}}, 1'b0);
    put_item(FUNC_SEARCH, {3{16'd5}}, 1'b1);
  endtask

  task automatic test_random_batches();
    logic [47:0] kept[$];
    bit          narrow;
    int          n_app;
    int          n_ops;
    int          r;
    for (int b = 0; b < 6; b++) begin
      src_idling  = ($urandom_range(0, 3) != 0);
      sink_idling = ($urandom_range(0, 3) != 0);
      narrow      = b[0];
      kept.delete();
      put_item(FUNC_CLEAR, rand_vec(1'b0), 1'($urandom_range(0, 1)));
      n_app = $urandom_range(0, 16);
      for (int i = 0; i < n_app; i++) begin
        kept.push_back(rand_vec(narrow));
        put_item(FUNC_APPEND, kept[$], 1'($urandom_range(0, 1)));
      end
      n_ops = $urandom_range(8, 16);
      for (int i = 0; i < n_ops; i++) begin
        r = $urandom_range(0, 99);
        if (r < 55 && kept.size() > 0)
          put_item(FUNC_SEARCH, kept[$urandom_range(0, kept.size() - 1)],
                   $urandom_range(0, 3) == 0);
        else if (r < 70 && kept.size() > 0)
          put_item(FUNC_SEARCH, near_miss(kept[$urandom_range(0, kept.size() - 1)]),
                   $urandom_range(0, 3) == 0);
        else if (r < 80)
          put_item(FUNC_SEARCH, rand_vec(narrow), $urandom_range(0, 3) == 0);
        else if (r < 90) begin
          kept.push_back(rand_vec(narrow));
          put_item(FUNC_APPEND, kept[$], 1'($urandom_range(0, 1)));
        end else
          put_item(FUNC_NONE, rand_vec(narrow), 1'($urandom_range(0, 1)));
      end
      put_item(FUNC_SEARCH, kept.size() > 0 ? kept[0] : rand_vec(narrow), 1'b1);
      if (b == 2) wait_drained();
    end
  endtask

  // fills every slot, overflows, and stalls the response side long enough
  // to back the chain up into the request channel
  task automatic test_full_table();
    logic [47:0] kept[$];
    src_idling     = 1'b1;
    sink_idling    = 1'b1;
    hold_on_result = 400;
    put_item(FUNC_CLEAR, 48'h0, 1'b0);
    put_item(FUNC_SEARCH, rand_vec(1'b0), 1'b0);
    for (int i = 0; i < DEPTH; i++) begin
      if (kept.size() > 0 && $urandom_range(0, 19) == 0)
        kept.push_back(kept[$urandom_range(0, kept.size() - 1)]);
      else
        kept.push_back(rand_vec(1'b0));
      put_item(FUNC_APPEND, kept[$], 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 11) == 0)
        put_item(FUNC_SEARCH, kept[$urandom_range(0, kept.size() - 1)],
                 1'($urandom_range(0, 1)));
      if (i == DEPTH / 2) src_idling = 1'b0;
    end
    src_idling = 1'b1;
    for (int i = 0; i < 8; i++) begin
      kept.push_back(rand_vec(1'b0));
      put_item(FUNC_APPEND, kept[$], 1'($urandom_range(0, 1)));
    end
    for (int i = 0; i < 8; i++) put_item(FUNC_SEARCH, kept[DEPTH + i], 1'b0);
    put_item(FUNC_SEARCH, kept[DEPTH - 1], 1'b1);
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(0, 3) == 0)
        put_item(FUNC_SEARCH, near_miss(kept[$urandom_range(0, DEPTH - 1)]),
                 1'($urandom_range(0, 1)));
      else
        put_item(FUNC_SEARCH, kept[$urandom_range(0, DEPTH - 1)],
                 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst                   = 1'b1;
    req_bus.valid         = 1'b0;
    req_bus.func          = FUNC_CLEAR;
    req_bus.coord_x       = '0;
    req_bus.coord_y       = '0;
    req_bus.coord_z       = '0;
    req_bus.last_in_batch = 1'b0;
    mirror_count          = 0;
    mismatch_count        = 0;
    src_idling            = 1'b0;
    sink_idling           = 1'b0;
    hold_on_result        = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_unused_code();
    test_field_extremes();
    test_duplicates();
    test_clear_hides_old();
    wait_drained();
    test_random_batches();
    wait_drained();
    test_full_table();

    @(negedge clk);
    req_bus.valid <= 1'b0;
    wait_drained();
    repeat (DEPTH + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
